>>> rtl/ncl1_pkg.sv
// Package for the nearest-centroid (L1) assignment block.
// Holds sizes, field widths, codes and the shared types. No dependencies.
package ncl1_pkg;

  // Table geometry
  localparam int MAX_CLUSTERS = 16;
  localparam int MAX_DIMS     = 1024;

  // Derived widths
  localparam int IDX_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CNT_W  = $clog2(MAX_CLUSTERS + 1);
  localparam int ADDR_W = (MAX_CLUSTERS * MAX_DIMS > 1) ?
                          $clog2(MAX_CLUSTERS * MAX_DIMS) : 1;

  // Field widths
  localparam int CLU_W  = 4;
  localparam int DIM_W  = 10;
  localparam int VAL_W  = 8;
  localparam int NEAR_W = 4;
  localparam int SUM_W  = 18;
  localparam int NUM_W  = 5;
  localparam int IN_W   = 24;
  localparam int OUT_W  = 24;

  // Register reset and accumulator ceiling
  localparam logic [NUM_W-1:0] NUM_RESET = NUM_W'(16);
  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};

  // Operation codes carried on tuser
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE,
    ST_HOLD
  } state_t;

  // What each cell of the accumulator ring receives
  typedef struct packed {
    logic             shift;
    logic [SUM_W-1:0] data;
  } ring_in_t;

endpackage

>>> rtl/ncl1_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ncl1_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/ncl1_cell.sv
// One cell of the accumulator ring: holds one centroid's running L1 sum
// and takes its neighbor's value on each shift. Depends on ncl1_pkg.
module ncl1_cell
  import ncl1_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ring_in_t         ring_in,
  output logic [SUM_W-1:0] acc
);

  logic [SUM_W-1:0] acc_r;
  logic [SUM_W-1:0] acc_nxt;

  // Take neighbor value while the ring rotates
  always_comb begin
    acc_nxt = acc_r;
    if (ring_in.shift) begin
      acc_nxt = ring_in.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign acc = acc_r;

endmodule

>>> rtl/nearest_centroid_l1_assign_top.sv
// A query transaction is accepted in ST_IDLE; after that in_tready stays low through ST_RUN,
// where one centroid is read per cycle through the single RAM read port, and ST_DONE, where
// the last read returns, and through ST_HOLD while the previous result is stalled.
// One load per cycle while idle; a new query coordinate is taken only once the last sweep is done.
// The result is loaded into the output slot from ST_DONE, or from ST_HOLD while the previous
// result is stalled. Reset clears the accumulators and sets num_clusters to 16.
module nearest_centroid_l1_assign_top
  import ncl1_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // Configuration
  input  logic             cfg_we,
  input  logic [NUM_W-1:0] cfg_wdata,   // num_clusters
  // Input stream
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,    // cluster[3:0], dimension[13:4], value[21:14]
  input  logic             in_tuser,    // operation
  input  logic             in_tlast,    // last
  // Result stream
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata    // nearest[3:0], distance[21:4]
);

  // Input field decode
  logic [CLU_W-1:0] in_cluster;
  logic [DIM_W-1:0] in_dim;
  logic [VAL_W-1:0] in_val;
  assign in_cluster = in_tdata[CLU_W-1:0];
  assign in_dim     = in_tdata[CLU_W+DIM_W-1:CLU_W];
  assign in_val     = in_tdata[CLU_W+DIM_W+VAL_W-1:CLU_W+DIM_W];

  // Control and payload registers
  state_t           state_r, state_nxt;
  logic [IDX_W-1:0] rd_k_r, rd_k_nxt;
  logic             proc_v_r;
  logic [IDX_W-1:0] proc_k_r;
  logic [VAL_W-1:0] val_r;
  logic [DIM_W-1:0] dim_r;
  logic             dim_ok_r;
  logic             last_r;
  logic [SUM_W-1:0] best_r, best_nxt;
  logic [IDX_W-1:0] best_idx_r, best_idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [NEAR_W-1:0] out_near_r;
  logic [SUM_W-1:0] out_dist_r;
  logic [NUM_W-1:0] num_clusters_r;

  logic in_acc, is_query, issue, out_load, slot_free;
  logic ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [VAL_W-1:0]  ram_rdata;

  // Active centroid count, clamped to 1..MAX_CLUSTERS
  logic [CNT_W-1:0] n_act;
  always_comb begin
    if (num_clusters_r == '0) begin
      n_act = CNT_W'(1);
    end else if (int'(num_clusters_r) > MAX_CLUSTERS) begin
      n_act = CNT_W'(MAX_CLUSTERS);
    end else begin
      n_act = CNT_W'(num_clusters_r);
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_clusters_r <= NUM_RESET;
    end else if (cfg_we) begin
      num_clusters_r <= cfg_wdata;
    end
  end

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign is_query  = (in_tuser == OP_QUERY);
  assign slot_free = !out_valid_r || out_tready;

  // Centroid memory: load writes, one read per cycle while sweeping
  assign ram_we    = in_acc && !is_query && (int'(in_cluster) < MAX_CLUSTERS)
                     && (int'(in_dim) < MAX_DIMS);
  assign ram_waddr = ADDR_W'(int'(in_cluster) * MAX_DIMS + int'(in_dim));
  assign ram_raddr = ADDR_W'(int'(rd_k_r) * MAX_DIMS + int'(dim_r));

  ncl1_ram #(
    .WIDTH (VAL_W),
    .DEPTH (MAX_CLUSTERS * MAX_DIMS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_val),
    .re    (issue),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Accumulator ring: cell 0 is the head, updated value re-enters at the tail
  logic [SUM_W-1:0] ring_q [MAX_CLUSTERS];
  ring_in_t         ring_in [MAX_CLUSTERS];
  logic [SUM_W-1:0] tail_data;

  for (genvar i = 0; i < MAX_CLUSTERS; i++) begin : g_ring
    if (i == MAX_CLUSTERS - 1) begin : g_tail
      assign ring_in[i].data = tail_data;
    end else begin : g_mid
      assign ring_in[i].data = ring_q[i+1];
    end
    assign ring_in[i].shift = proc_v_r;

    ncl1_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ring_in (ring_in[i]),
      .acc     (ring_q[i])
    );
  end

  // Head update: |q - c|, saturating add, running minimum
  logic [VAL_W-1:0] diff;
  logic [SUM_W:0]   sum_wide;
  logic [SUM_W-1:0] sum_sat, head_new;
  logic             active;
  always_comb begin
    if (!dim_ok_r) begin
      diff = '0;
    end else if (val_r > ram_rdata) begin
      diff = val_r - ram_rdata;
    end else begin
      diff = ram_rdata - val_r;
    end
    sum_wide = {1'b0, ring_q[0]} + (SUM_W+1)'(diff);
    sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    active   = CNT_W'(proc_k_r) < n_act;
    head_new = active ? sum_sat : ring_q[0];
    // Last coordinate clears every accumulator on its way round
    tail_data = last_r ? '0 : head_new;

    best_nxt     = best_r;
    best_idx_nxt = best_idx_r;
    if (proc_v_r && active && ((proc_k_r == '0) || (sum_sat < best_r))) begin
      best_nxt     = sum_sat;
      best_idx_nxt = proc_k_r;
    end
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    rd_k_nxt  = rd_k_r;
    issue     = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && is_query) begin
          rd_k_nxt  = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        issue    = 1'b1;
        rd_k_nxt = rd_k_r + IDX_W'(1);
        if (rd_k_r == IDX_W'(MAX_CLUSTERS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!last_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Output slot valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_k_r      <= '0;
      proc_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rd_k_r      <= rd_k_nxt;
      proc_v_r    <= issue;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    proc_k_r   <= rd_k_r;
    best_r     <= best_nxt;
    best_idx_r <= best_idx_nxt;
    if (in_acc && is_query) begin
      val_r    <= in_val;
      dim_r    <= in_dim;
      dim_ok_r <= int'(in_dim) < MAX_DIMS;
      last_r   <= in_tlast;
    end
    if (out_load) begin
      out_near_r <= NEAR_W'(best_idx_nxt);
      out_dist_r <= best_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_W-NEAR_W-SUM_W)'(0), out_dist_r, out_near_r};

  // Assertions
  a_proc_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    proc_v_r |-> (state_r == ST_RUN || state_r == ST_DONE))
    else $error("head update outside a sweep");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !proc_v_r)
    else $error("ring rotating while idle");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(last_r))
    else $error("result without a last coordinate");

  a_no_ram_clash: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !issue)
    else $error("centroid write during a sweep");

endmodule

>>> verif/nearest_centroid_l1_assign_top_test.sv
// Self-checking test for nearest_centroid_l1_assign_top: loads centroids,
// streams query vectors and checks each nearest-centroid result against a
// local predictor. Depends on ncl1_pkg and the RTL of the block.
`timescale 1ns / 100ps

module nearest_centroid_l1_assign_top_test;
  import ncl1_pkg::*;

  localparam int DRAIN_CYCLES   = 3 * (MAX_CLUSTERS + 1) + 8;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 10;

  // One nearest-centroid answer
  typedef struct {
    logic [NEAR_W-1:0] nearest;
    logic [SUM_W-1:0]  distance;
  } assign_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [NUM_W-1:0] cfg_wdata = '0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;    // cluster, dimension, value
  logic             in_tuser = 1'b0;  // operation
  logic             in_tlast = 1'b0;  // last
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;        // nearest, distance

  // Predictor state
  logic [VAL_W-1:0] centroid_mem [MAX_CLUSTERS][MAX_DIMS];
  logic [SUM_W-1:0] l1_sum [MAX_CLUSTERS] = '{default: '0};
  logic [NUM_W-1:0] cluster_cfg = NUM_RESET;
  assign_t          pending_assign [$];

  // Dimensions written for every centroid, safe to query
  bit               dim_ready [MAX_DIMS];
  int unsigned      ready_dims [$];

  int unsigned      fail_count = 0;
  int unsigned      result_count = 0;
  int unsigned      burst_left = 0;
  int unsigned      idle_cycles = 0;
  logic [8:0]       ready_tick = '0;

  nearest_centroid_l1_assign_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #1 clk = ~clk;

  // Apply one accepted transaction to the predictor
  function automatic void step_l1_search(logic op, logic [CLU_W-1:0] clu,
                                         logic [DIM_W-1:0] dim, logic [VAL_W-1:0] val,
                                         logic last);
    int               n;
    logic [VAL_W-1:0] c;
    logic [VAL_W-1:0] d;
    logic [SUM_W:0]   s;
    logic [NEAR_W-1:0] best;
    logic [SUM_W-1:0] best_sum;
    assign_t          res;
    if (cluster_cfg == 0) n = 1;
    else if (cluster_cfg > MAX_CLUSTERS) n = MAX_CLUSTERS;
    else n = cluster_cfg;
    if (op == OP_LOAD) begin
      centroid_mem[clu][dim] = val;
      return;
    end
    for (int k = 0; k < n; k++) begin
      c = centroid_mem[k][dim];
      d = (val > c) ? val - c : c - val;
      s = {1'b0, l1_sum[k]} + d;
      l1_sum[k] = (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
    end
    if (!last) return;
    // strict compare keeps the lower index on ties
    best = '0;
    best_sum = l1_sum[0];
    for (int k = 1; k < n; k++) begin
      if (l1_sum[k] < best_sum) begin
        best_sum = l1_sum[k];
        best = NEAR_W'(k);
      end
    end
    res.nearest = best;
    res.distance = best_sum;
    pending_assign.insert(pending_assign.size(), res);
    for (int k = 0; k < MAX_CLUSTERS; k++) l1_sum[k] = '0;
  endfunction

  // Send one input transaction, with bursty gaps
  task automatic send_coord(input logic op, input logic [CLU_W-1:0] clu,
                            input logic [DIM_W-1:0] dim, input logic [VAL_W-1:0] val,
                            input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tlast  <= last;
    in_tdata  <= {{(IN_W - CLU_W - DIM_W - VAL_W){1'b0}}, val, dim, clu};
    do @(posedge clk); while (!in_tready);
    step_l1_search(op, clu, dim, val, last);
  endtask

  // Drop valid, let all results come out and the pipeline empty
  task automatic wait_block_idle();
    in_tvalid <= 1'b0;
    while (pending_assign.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_cluster_count(input logic [NUM_W-1:0] count);
    wait_block_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    cluster_cfg = count;
  endtask

  // Load one dimension for every centroid so queries may use it
  task automatic fill_dimension(input logic [DIM_W-1:0] dim);
    for (int k = 0; k < MAX_CLUSTERS; k++)
      send_coord(OP_LOAD, CLU_W'(k), dim, VAL_W'($urandom), 1'($urandom));
    if (!dim_ready[dim]) begin
      dim_ready[dim] = 1'b1;
      ready_dims.insert(ready_dims.size(), dim);
    end
  endtask

  // Ramp table at the extreme dimensions; tlast and odd fields on loads are don't-care
  task automatic test_table_fill();
    for (int k = 0; k < MAX_CLUSTERS; k++) begin
      send_coord(OP_LOAD, CLU_W'(k), '0, VAL_W'(k * 17), 1'(k));
      send_coord(OP_LOAD, CLU_W'(k), {DIM_W{1'b1}}, VAL_W'(255 - k * 17), ~1'(k));
    end
    dim_ready[0] = 1'b1;
    dim_ready[MAX_DIMS-1] = 1'b1;
    ready_dims.insert(ready_dims.size(), 0);
    ready_dims.insert(ready_dims.size(), MAX_DIMS - 1);
  endtask

  // Reset cluster count, value extremes, single-item vectors, tie to lower index
  task automatic test_query_extremes();
    send_coord(OP_QUERY, '0, '0, '0, 1'b1);
    send_coord(OP_QUERY, {CLU_W{1'b1}}, '0, {VAL_W{1'b1}}, 1'b1);
    send_coord(OP_QUERY, {CLU_W{1'b1}}, {DIM_W{1'b1}}, {VAL_W{1'b1}}, 1'b1);
    send_coord(OP_QUERY, 4'h5, '0, 8'd128, 1'b0);
    send_coord(OP_QUERY, 4'ha, {DIM_W{1'b1}}, 8'd128, 1'b1);
  endtask

  // Count of one, zero (treated as one), above range and in between
  task automatic test_cluster_count();
    set_cluster_count(5'd1);
    send_coord(OP_QUERY, '0, '0, 8'hff, 1'b1);
    set_cluster_count(5'd0);
    send_coord(OP_QUERY, '0, {DIM_W{1'b1}}, 8'h00, 1'b1);
    set_cluster_count(5'd31);
    send_coord(OP_QUERY, '0, '0, 8'd200, 1'b1);
    set_cluster_count(5'd5);
    send_coord(OP_QUERY, '0, '0, 8'hff, 1'b0);
    send_coord(OP_QUERY, '0, {DIM_W{1'b1}}, 8'hff, 1'b1);
  endtask

  // Count changes between coordinates of one vector
  task automatic test_mid_query_config();
    set_cluster_count(5'd16);
    send_coord(OP_QUERY, '0, '0, 8'hff, 1'b0);
    set_cluster_count(5'd2);
    send_coord(OP_QUERY, '0, {DIM_W{1'b1}}, 8'h00, 1'b1);
    send_coord(OP_QUERY, '0, '0, 8'hff, 1'b0);
    set_cluster_count(5'd16);
    // upper centroids join with a fresh accumulator and win
    send_coord(OP_QUERY, '0, {DIM_W{1'b1}}, 8'h00, 1'b1);
  endtask

  // Centroid load between coordinates, then a repeated dimension
  task automatic test_load_during_query();
    send_coord(OP_QUERY, '0, '0, 8'd100, 1'b0);
    send_coord(OP_LOAD, 4'd3, '0, 8'd100, 1'b1);
    send_coord(OP_QUERY, '0, '0, 8'd100, 1'b1);
  endtask

  // Random vectors over loaded dimensions, mixed with loads
  task automatic test_random_traffic();
    int unsigned      sent;
    int unsigned      len;
    int unsigned      pick;
    logic [DIM_W-1:0] dim;
    repeat (6) begin
      set_cluster_count(NUM_W'($urandom_range(0, 31)));
      sent = 0;
      while (sent < 65) begin
        pick = $urandom_range(0, 99);
        if (pick < 10 && ready_dims.size() < 40) begin
          fill_dimension(DIM_W'($urandom));
          sent += MAX_CLUSTERS;
        end else if (pick < 25) begin
          send_coord(OP_LOAD, CLU_W'($urandom), DIM_W'($urandom), VAL_W'($urandom),
                     1'($urandom));
          sent++;
        end else begin
          len = $urandom_range(1, 6);
          for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) begin
              send_coord(OP_LOAD, CLU_W'($urandom), DIM_W'($urandom), VAL_W'($urandom),
                         1'($urandom));
              sent++;
            end
            dim = DIM_W'(ready_dims[$urandom_range(0, ready_dims.size() - 1)]);
            send_coord(OP_QUERY, CLU_W'($urandom), dim, VAL_W'($urandom),
                       1'(i == len - 1));
          end
          sent += len;
        end
      end
    end
  endtask

  // Receiver stall pattern: ready, coin flip, mostly stalled, toggling
  always @(posedge clk) begin
    ready_tick <= ready_tick + 1'b1;
    case (ready_tick[8:7])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= 1'($urandom);
      2'd2: out_tready <= ($urandom_range(0, 3) == 0);
      default: out_tready <= ready_tick[0];
    endcase
  end

  // Result check and watchdog
  always @(posedge clk) begin
    assign_t exp_res;
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
      if (out_tvalid && out_tready) begin
        result_count <= result_count + 1;
        if (pending_assign.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("result %0d: unexpected transaction, nearest %0d distance %0d",
                     result_count, out_tdata[3:0], out_tdata[21:4]);
          fail_count <= fail_count + 1;
        end else begin
          exp_res = pending_assign.pop_front();
          if (out_tdata[3:0] !== exp_res.nearest || out_tdata[21:4] !== exp_res.distance) begin
            if (fail_count < MAX_REPORTS)
              $display("result %0d: expected nearest %0d distance %0d, got nearest %0d distance %0d",
                       result_count, exp_res.nearest, exp_res.distance,
                       out_tdata[3:0], out_tdata[21:4]);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_fill();
    test_query_extremes();
    test_cluster_count();
    test_mid_query_config();
    test_load_during_query();
    test_random_traffic();
    wait_block_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ncl1_pkg.sv
rtl/ncl1_ram.sv
rtl/ncl1_cell.sv
rtl/nearest_centroid_l1_assign_top.sv
verif/nearest_centroid_l1_assign_top_test.sv
